FILE: design/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int FIELD_W       = 32;
  localparam int KIND_W        = 4;
  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [KIND_W-1:0] {
    K_ADD    = 4'd0,
    K_SUB    = 4'd1,
    K_MUL    = 4'd2,
    K_DIV    = 4'd3,
    K_EQ     = 4'd4,
    K_NE     = 4'd5,
    K_LT     = 4'd6,
    K_LE     = 4'd7,
    K_GT     = 4'd8,
    K_GE     = 4'd9,
    K_MIN    = 4'd10,
    K_MAX    = 4'd11,
    K_INC    = 4'd12,
    K_DEC    = 4'd13,
    K_TO_INT = 4'd14
  } kind_t;

  // Result data that rides along the divider row next to each beat.
  typedef struct packed {
    logic               use_div;
    logic               neg;
    logic [FIELD_W-1:0] value;
    logic               cmp;
    logic               sat;
  } side_t;

endpackage

FILE: design/fpa_prep.sv
// Front end: operand capture, non-divide results, multiply and divider setup.
`timescale 1ns / 1ps

module fpa_prep import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [FIELD_W-1:0] operand_a,
  input  logic signed [FIELD_W-1:0] operand_b,
  output logic                      out_valid,
  output side_t                     out_side,
  output logic [((WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W)+FRAC_BITS-1:0] out_num,
  output logic [((WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W)-1:0]           out_div
);

  localparam int     EW   = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
  localparam int     SH   = FIELD_W - EW;
  localparam longint HI_L = (longint'(1) <<< (EW - 1)) - longint'(1);
  localparam longint LO_L = -HI_L - longint'(1);

  // {saturated, value}
  function automatic logic [FIELD_W:0] clamp_word(input longint v);
    logic [FIELD_W:0] r;
    if (v > HI_L) begin
      r = {1'b1, FIELD_W'(HI_L)};
    end else if (v < LO_L) begin
      r = {1'b1, FIELD_W'(LO_L)};
    end else begin
      r = {1'b0, FIELD_W'(v)};
    end
    return r;
  endfunction

  // stage 1: capture, operands sign-extended from the word width
  logic                      v1;
  logic [KIND_W-1:0]         k1;
  logic signed [FIELD_W-1:0] a1;
  logic signed [FIELD_W-1:0] b1;
  logic [FIELD_W-1:0]        a_shl;
  logic [FIELD_W-1:0]        b_shl;

  assign a_shl = operand_a << SH;
  assign b_shl = operand_b << SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1 <= kind;
      a1 <= $signed(a_shl) >>> SH;
      b1 <= $signed(b_shl) >>> SH;
    end
  end

  // stage 2: product, simple ops, magnitudes
  logic signed [2*FIELD_W-1:0] prod_c;
  logic signed [FIELD_W:0]     sum_c;
  logic signed [FIELD_W:0]     diff_c;
  logic signed [FIELD_W:0]     inc_c;
  logic signed [FIELD_W:0]     dec_c;
  logic [FIELD_W-1:0]          abs_a;
  logic [FIELD_W-1:0]          abs_b;
  logic [FIELD_W:0]            clp;
  side_t                       side_c;

  assign prod_c = a1 * b1;
  assign sum_c  = {a1[FIELD_W-1], a1} + {b1[FIELD_W-1], b1};
  assign diff_c = {a1[FIELD_W-1], a1} - {b1[FIELD_W-1], b1};
  assign inc_c  = {a1[FIELD_W-1], a1} + (FIELD_W+1)'(1);
  assign dec_c  = {a1[FIELD_W-1], a1} - (FIELD_W+1)'(1);
  assign abs_a  = a1[FIELD_W-1] ? (~a1 + FIELD_W'(1)) : a1;
  assign abs_b  = b1[FIELD_W-1] ? (~b1 + FIELD_W'(1)) : b1;

  always_comb begin
    side_c = '0;
    clp    = '0;
    unique case (k1)
      K_ADD: begin
        clp = clamp_word(longint'(sum_c));
        side_c.value = clp[FIELD_W-1:0];
        side_c.sat   = clp[FIELD_W];
      end
      K_SUB: begin
        clp = clamp_word(longint'(diff_c));
        side_c.value = clp[FIELD_W-1:0];
        side_c.sat   = clp[FIELD_W];
      end
      K_MUL: begin
      end
      K_DIV: begin
        // divide by zero returns a untouched
        side_c.use_div = (b1 != '0);
        side_c.neg     = a1[FIELD_W-1] ^ b1[FIELD_W-1];
        side_c.value   = a1;
      end
      K_EQ: side_c.cmp = (a1 == b1);
      K_NE: side_c.cmp = (a1 != b1);
      K_LT: side_c.cmp = (a1 < b1);
      K_LE: side_c.cmp = (a1 <= b1);
      K_GT: side_c.cmp = (a1 > b1);
      K_GE: side_c.cmp = (a1 >= b1);
      K_MIN: side_c.value = (a1 > b1) ? b1 : a1;
      K_MAX: side_c.value = (a1 >= b1) ? a1 : b1;
      K_INC: begin
        clp = clamp_word(longint'(inc_c));
        side_c.value = clp[FIELD_W-1:0];
        side_c.sat   = clp[FIELD_W];
      end
      K_DEC: begin
        clp = clamp_word(longint'(dec_c));
        side_c.value = clp[FIELD_W-1:0];
        side_c.sat   = clp[FIELD_W];
      end
      K_TO_INT: side_c.value = a1 >>> FRAC_BITS;
      default: begin
      end
    endcase
  end

  logic                        v2;
  logic                        mul2;
  side_t                       side2;
  logic signed [2*FIELD_W-1:0] prod2;
  logic [EW-1:0]               mag_a2;
  logic [EW-1:0]               mag_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul2   <= (k1 == K_MUL);
      side2  <= side_c;
      prod2  <= prod_c;
      mag_a2 <= abs_a[EW-1:0];
      mag_b2 <= abs_b[EW-1:0];
    end
  end

  // stage 3: truncate the product toward zero, then clamp
  logic signed [2*FIELD_W-1:0] bias;
  logic signed [2*FIELD_W-1:0] trunc;
  logic [FIELD_W:0]            mclp;
  side_t                       side3_c;

  assign bias  = prod2[2*FIELD_W-1] ? ((2*FIELD_W)'(1) <<< FRAC_BITS) - (2*FIELD_W)'(1) : '0;
  assign trunc = (prod2 + bias) >>> FRAC_BITS;
  assign mclp  = clamp_word(longint'(trunc));

  always_comb begin
    side3_c = side2;
    if (mul2) begin
      side3_c.value = mclp[FIELD_W-1:0];
      side3_c.sat   = mclp[FIELD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side3_c;
      out_num  <= {mag_a2, {FRAC_BITS{1'b0}}};
      out_div  <= mag_b2;
    end
  end

endmodule

FILE: design/fpa_div_cell.sv
// One restoring-division cell: produces one quotient bit per beat.
`timescale 1ns / 1ps

module fpa_div_cell import fpa_pkg::*; #(
  parameter int EW = FIELD_W,
  parameter int DW = FIELD_W + FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  side_t         in_side,
  input  logic [EW-1:0] in_rem,
  input  logic [DW-1:0] in_num,
  input  logic [EW-1:0] in_div,
  output logic          out_valid,
  output side_t         out_side,
  output logic [EW-1:0] out_rem,
  output logic [DW-1:0] out_num,
  output logic [EW-1:0] out_div
);

  logic [EW:0]   trial;
  logic          ge;
  logic [EW:0]   diff;

  // bring down the next dividend bit, subtract when it fits
  assign trial = {in_rem, in_num[DW-1]};
  assign ge    = (trial >= {1'b0, in_div});
  assign diff  = trial - {1'b0, in_div};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_rem  <= ge ? diff[EW-1:0] : trial[EW-1:0];
      out_num  <= {in_num[DW-2:0], ge};
      out_div  <= in_div;
    end
  end

endmodule

FILE: design/fixed_point_alu.sv
// Top level of the signed fixed-point ALU.
//
// Request channel: kind, operand_a, operand_b, taken on a rising edge with
// req_valid high and req_stall low. Response channel: value, compare_true,
// saturated, handed over on an edge with rsp_valid high and rsp_stall low.
// Each request yields exactly one response, in order.
//
// Each request passes three front-end stages, one stage per quotient bit in
// the divider row, and the output register. Every operation travels the same
// row, so one request is taken per cycle for any mix of kinds while the
// output register is not held by rsp_stall.
//
// The whole pipeline advances together. While a response sits in the output
// register and rsp_stall is high, every stage holds and req_stall is raised;
// bubbles are carried, not squeezed out.
//
// Reset clears every valid bit in the pipeline and the output register;
// nothing else needs initializing.
`timescale 1ns / 1ps

module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [FIELD_W-1:0] operand_a,
  input  logic signed [FIELD_W-1:0] operand_b,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [FIELD_W-1:0] value,
  output logic                      compare_true,
  output logic                      saturated
);

  localparam int         EW      = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
  localparam int         DW      = EW + FRAC_BITS;
  localparam logic [63:0] POS_MAX = (64'd1 << (EW - 1)) - 64'd1;
  localparam logic [63:0] NEG_MAX = 64'd1 << (EW - 1);
  localparam logic [63:0] NEG_LIM = 64'd0 - NEG_MAX;

  logic en;

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  logic          v_c    [DW+1];
  side_t         side_c [DW+1];
  logic [EW-1:0] rem_c  [DW];
  logic [DW-1:0] num_c  [DW+1];
  logic [EW-1:0] div_c  [DW];

  fpa_prep #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .kind      (kind),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (v_c[0]),
    .out_side  (side_c[0]),
    .out_num   (num_c[0]),
    .out_div   (div_c[0])
  );

  assign rem_c[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    if (i < DW - 1) begin : g_mid
      fpa_div_cell #(
        .EW (EW),
        .DW (DW)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (v_c[i]),
        .in_side   (side_c[i]),
        .in_rem    (rem_c[i]),
        .in_num    (num_c[i]),
        .in_div    (div_c[i]),
        .out_valid (v_c[i+1]),
        .out_side  (side_c[i+1]),
        .out_rem   (rem_c[i+1]),
        .out_num   (num_c[i+1]),
        .out_div   (div_c[i+1])
      );
    end else begin : g_last
      // final remainder and divisor are not needed past the row
      fpa_div_cell #(
        .EW (EW),
        .DW (DW)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (v_c[i]),
        .in_side   (side_c[i]),
        .in_rem    (rem_c[i]),
        .in_num    (num_c[i]),
        .in_div    (div_c[i]),
        .out_valid (v_c[i+1]),
        .out_side  (side_c[i+1]),
        .out_rem   (),
        .out_num   (num_c[i+1]),
        .out_div   ()
      );
    end
  end

  // apply the quotient sign and clamp; other kinds pass their result through
  side_t              fin;
  logic [63:0]        q64;
  logic [63:0]        nq64;
  logic [FIELD_W-1:0] val_c;
  logic               sat_c;

  assign fin  = side_c[DW];
  assign q64  = 64'(num_c[DW]);
  assign nq64 = 64'd0 - q64;

  always_comb begin
    val_c = fin.value;
    sat_c = fin.sat;
    if (fin.use_div) begin
      if (fin.neg) begin
        if (q64 > NEG_MAX) begin
          val_c = NEG_LIM[FIELD_W-1:0];
          sat_c = 1'b1;
        end else begin
          val_c = nq64[FIELD_W-1:0];
          sat_c = 1'b0;
        end
      end else begin
        if (q64 > POS_MAX) begin
          val_c = POS_MAX[FIELD_W-1:0];
          sat_c = 1'b1;
        end else begin
          val_c = q64[FIELD_W-1:0];
          sat_c = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= v_c[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value        <= val_c;
      compare_true <= fin.cmp;
      saturated    <= sat_c;
    end
  end

endmodule
